// ===== rtl/ffra_pkg.sv =====
package ffra_pkg;

   localparam int OFS_W = 24;
   localparam int SIZE_W = 25;
   localparam logic [SIZE_W-1:0] BLOCK_MAX = SIZE_W'(1) << OFS_W;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 56;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE = 1'b1;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_NOFIT = 3'd1,
      ST_NOTALLOC = 3'd2,
      ST_FULL = 3'd3,
      ST_ZERO = 3'd4
   } status_type;

   typedef struct packed {
      logic [OFS_W-1:0] start;
      logic [OFS_W-1:0] stop;
   } region_type;

endpackage

// ===== rtl/ffra_table.sv =====
module ffra_table #(
   parameter int DEPTH = 64,
   parameter int IW = 6
) (
   input  logic                      clock,
   input  logic                      start_we,
   input  logic [IW-1:0]             start_addr,
   input  logic [ffra_pkg::OFS_W-1:0] start_data,
   input  logic                      end_we,
   input  logic [IW-1:0]             end_addr,
   input  logic [ffra_pkg::OFS_W-1:0] end_data,
   input  logic [IW-1:0]             rd_addr,
   output ffra_pkg::region_type      rd_region
);
   import ffra_pkg::*;

   logic [OFS_W-1:0] start_mem [DEPTH];
   logic [OFS_W-1:0] end_mem [DEPTH];
   region_type rd_ff;

   always_ff @(posedge clock) begin
      if (start_we) begin
         start_mem[start_addr] <= start_data;
      end
      if (end_we) begin
         end_mem[end_addr] <= end_data;
      end
      rd_ff.start <= start_mem[rd_addr];
      rd_ff.stop <= end_mem[rd_addr];
   end

   assign rd_region = rd_ff;

endmodule

// ===== rtl/first_fit_region_allocator_core.sv =====
// First-fit byte-range allocator with merging of free neighbors.
// Request channel (req_): tuser carries the opcode (allocate or free), tdata
// the request size and the offset to release. Response channel (rsp_): one
// response per request with status, granted offset and bytes in use.
// csr_we/csr_wdata set the block size; a write starts a fresh table with one
// free region covering the whole block. The user must make the write only
// while idle; the block itself does not enforce it. The region table sits
// in a single-read-port memory, so allocate and free walk it one entry per
// cycle. Allocate: a walk for a free region (S_ASCAN), S_ADEC, S_AWR2 when
// a region is split, S_DONE. Free: a walk for the region (S_FSCAN1), S_FDEC,
// a walk for its neighbors (S_FSCAN2), S_FUPD, S_DONE; only the first walk
// when the offset is not in use. Zero-size allocate goes straight to S_DONE.
// One request is in work at a time; req_tready is high only while idle, so
// the next request can be taken in the cycle after the response is loaded.
// The response sits in an output register, so a new request is accepted
// while an earlier response waits for rsp_tready; a stalled response holds.
// After reset (or a block size write) S_INIT writes the first table entry
// before the first request is taken; the block size resets to 2^24.
module first_fit_region_allocator_core #(
   parameter int MAX_REGIONS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [24:0] request_size, [48:25] free_offset, rest zero
   input  logic [ffra_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] opcode
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [2:0] status, [26:3] granted_offset, [51:27] used_bytes, rest zero
   output logic [ffra_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                              csr_we,
   input  logic [ffra_pkg::SIZE_W-1:0]       csr_wdata
);
   import ffra_pkg::*;

   localparam int IW = $clog2(MAX_REGIONS);
   localparam int CW = $clog2(MAX_REGIONS + 1);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_ASCAN, S_ADEC, S_AWR2,
      S_FSCAN1, S_FDEC, S_FSCAN2, S_FUPD, S_DONE
   } state_type;

   state_type state_ff;
   logic [SIZE_W-1:0] bb_ff, total_ff, size_ff;
   logic [OFS_W-1:0] ofs_ff;
   logic [MAX_REGIONS-1:0] valid_ff, used_ff;
   logic [CW-1:0] cnt_ff;
   logic chk_vld_ff;
   logic [IW-1:0] chk_idx_ff;
   logic best_found_ff, spare_found_ff, cur_found_ff, bef_found_ff, aft_found_ff;
   logic [IW-1:0] best_idx_ff, spare_idx_ff, cur_idx_ff, bef_idx_ff, aft_idx_ff;
   logic [OFS_W-1:0] best_start_ff, best_end_ff, cur_end_ff, aft_end_ff;
   logic [SIZE_W-1:0] best_size_ff, cur_size_ff;
   status_type status_ff;
   logic [OFS_W-1:0] granted_ff;
   logic rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;

   region_type rd_region;
   logic scanning, chk_vld_in, rsp_load;
   logic [SIZE_W-1:0] ent_size, req_size, bb_in;
   logic ent_valid, ent_used;
   logic alloc_hit, spare_hit, cur_hit, bef_hit, aft_hit, exact;
   logic start_we, end_we;
   logic [IW-1:0] start_addr, end_addr;
   logic [OFS_W-1:0] start_data, end_data;

   assign req_size = req_tdata[SIZE_W-1:0];
   assign scanning = (state_ff == S_ASCAN) || (state_ff == S_FSCAN1) ||
                     (state_ff == S_FSCAN2);
   assign chk_vld_in = scanning && (cnt_ff < CW'(MAX_REGIONS));
   assign rsp_load = (state_ff == S_DONE) && (!rsp_tvalid_ff || rsp_tready);

   ffra_table #(.DEPTH(MAX_REGIONS), .IW(IW)) u_table (
      .clock      (clock),
      .start_we   (start_we),
      .start_addr (start_addr),
      .start_data (start_data),
      .end_we     (end_we),
      .end_addr   (end_addr),
      .end_data   (end_data),
      .rd_addr    (cnt_ff[IW-1:0]),
      .rd_region  (rd_region)
   );

   // entry under test, read out in the cycle after its read address
   assign ent_size = {1'b0, rd_region.stop} - {1'b0, rd_region.start} + SIZE_W'(1);
   assign ent_valid = valid_ff[chk_idx_ff];
   assign ent_used = used_ff[chk_idx_ff];
   assign alloc_hit = chk_vld_ff && ent_valid && !ent_used && (ent_size >= size_ff) &&
                      (!best_found_ff || (rd_region.start < best_start_ff));
   assign spare_hit = chk_vld_ff && !ent_valid && !spare_found_ff;
   assign cur_hit = chk_vld_ff && ent_valid && ent_used && (rd_region.start == ofs_ff);
   assign bef_hit = chk_vld_ff && (chk_idx_ff != cur_idx_ff) && ent_valid && !ent_used &&
                    (ofs_ff != '0) && (rd_region.stop == ofs_ff - OFS_W'(1));
   assign aft_hit = chk_vld_ff && (chk_idx_ff != cur_idx_ff) && ent_valid && !ent_used &&
                    ({1'b0, rd_region.start} == {1'b0, cur_end_ff} + SIZE_W'(1));
   assign exact = (best_size_ff == size_ff);

   always_comb begin
      if (csr_wdata == '0) begin
         bb_in = SIZE_W'(1);
      end else if (csr_wdata > BLOCK_MAX) begin
         bb_in = BLOCK_MAX;
      end else begin
         bb_in = csr_wdata;
      end
   end

   always_comb begin
      start_we = 1'b0;
      start_addr = '0;
      start_data = '0;
      end_we = 1'b0;
      end_addr = '0;
      end_data = '0;
      case (state_ff)
         S_INIT: begin
            start_we = 1'b1;
            end_we = 1'b1;
            end_data = OFS_W'(bb_ff - SIZE_W'(1));
         end
         S_ADEC: begin
            // split: the free remainder goes to the spare entry
            if (best_found_ff && !exact && spare_found_ff) begin
               start_we = 1'b1;
               start_addr = spare_idx_ff;
               start_data = best_start_ff + size_ff[OFS_W-1:0];
               end_we = 1'b1;
               end_addr = spare_idx_ff;
               end_data = best_end_ff;
            end
         end
         S_AWR2: begin
            end_we = 1'b1;
            end_addr = best_idx_ff;
            end_data = best_start_ff + size_ff[OFS_W-1:0] - OFS_W'(1);
         end
         S_FUPD: begin
            end_we = 1'b1;
            end_addr = bef_found_ff ? bef_idx_ff : cur_idx_ff;
            end_data = aft_found_ff ? aft_end_ff : cur_end_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         bb_ff <= BLOCK_MAX;
         total_ff <= '0;
         valid_ff <= '0;
         used_ff <= '0;
         cnt_ff <= '0;
         chk_vld_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         chk_vld_ff <= chk_vld_in;
         chk_idx_ff <= cnt_ff[IW-1:0];
         if (chk_vld_in) begin
            cnt_ff <= cnt_ff + CW'(1);
         end
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
            rsp_tdata_ff <= {(RSP_TDATA_W - SIZE_W - OFS_W - 3)'(0),
                             total_ff, granted_ff, status_ff};
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (csr_we) begin
            bb_ff <= bb_in;
            state_ff <= S_INIT;
         end else begin
            case (state_ff)
               S_INIT: begin
                  valid_ff <= MAX_REGIONS'(1);
                  used_ff <= '0;
                  total_ff <= '0;
                  state_ff <= S_IDLE;
               end
               S_IDLE: begin
                  if (req_tvalid) begin
                     size_ff <= req_size;
                     ofs_ff <= req_tdata[SIZE_W +: OFS_W];
                     cnt_ff <= '0;
                     granted_ff <= '0;
                     best_found_ff <= 1'b0;
                     spare_found_ff <= 1'b0;
                     cur_found_ff <= 1'b0;
                     if (req_tuser[0] == OP_FREE) begin
                        state_ff <= S_FSCAN1;
                     end else if (req_size == '0) begin
                        status_ff <= ST_ZERO;
                        state_ff <= S_DONE;
                     end else begin
                        state_ff <= S_ASCAN;
                     end
                  end
               end
               S_ASCAN: begin
                  if (alloc_hit) begin
                     best_found_ff <= 1'b1;
                     best_idx_ff <= chk_idx_ff;
                     best_start_ff <= rd_region.start;
                     best_end_ff <= rd_region.stop;
                     best_size_ff <= ent_size;
                  end
                  if (spare_hit) begin
                     spare_found_ff <= 1'b1;
                     spare_idx_ff <= chk_idx_ff;
                  end
                  if (!chk_vld_in) begin
                     state_ff <= S_ADEC;
                  end
               end
               S_ADEC: begin
                  if (!best_found_ff) begin
                     status_ff <= ST_NOFIT;
                     state_ff <= S_DONE;
                  end else if (exact) begin
                     used_ff[best_idx_ff] <= 1'b1;
                     total_ff <= total_ff + size_ff;
                     granted_ff <= best_start_ff;
                     status_ff <= ST_OK;
                     state_ff <= S_DONE;
                  end else if (!spare_found_ff) begin
                     status_ff <= ST_FULL;
                     state_ff <= S_DONE;
                  end else begin
                     valid_ff[spare_idx_ff] <= 1'b1;
                     used_ff[spare_idx_ff] <= 1'b0;
                     used_ff[best_idx_ff] <= 1'b1;
                     total_ff <= total_ff + size_ff;
                     granted_ff <= best_start_ff;
                     status_ff <= ST_OK;
                     state_ff <= S_AWR2;
                  end
               end
               S_AWR2: begin
                  state_ff <= S_DONE;
               end
               S_FSCAN1: begin
                  if (cur_hit) begin
                     cur_found_ff <= 1'b1;
                     cur_idx_ff <= chk_idx_ff;
                     cur_end_ff <= rd_region.stop;
                     cur_size_ff <= ent_size;
                  end
                  if (!chk_vld_in) begin
                     state_ff <= S_FDEC;
                  end
               end
               S_FDEC: begin
                  if (!cur_found_ff) begin
                     status_ff <= ST_NOTALLOC;
                     state_ff <= S_DONE;
                  end else begin
                     cnt_ff <= '0;
                     bef_found_ff <= 1'b0;
                     aft_found_ff <= 1'b0;
                     state_ff <= S_FSCAN2;
                  end
               end
               S_FSCAN2: begin
                  if (bef_hit) begin
                     bef_found_ff <= 1'b1;
                     bef_idx_ff <= chk_idx_ff;
                  end
                  if (aft_hit) begin
                     aft_found_ff <= 1'b1;
                     aft_idx_ff <= chk_idx_ff;
                     aft_end_ff <= rd_region.stop;
                  end
                  if (!chk_vld_in) begin
                     state_ff <= S_FUPD;
                  end
               end
               S_FUPD: begin
                  used_ff[cur_idx_ff] <= 1'b0;
                  if (bef_found_ff) begin
                     valid_ff[cur_idx_ff] <= 1'b0;
                  end
                  if (aft_found_ff) begin
                     valid_ff[aft_idx_ff] <= 1'b0;
                  end
                  total_ff <= total_ff - cur_size_ff;
                  status_ff <= ST_OK;
                  state_ff <= S_DONE;
               end
               S_DONE: begin
                  if (rsp_load) begin
                     state_ff <= S_IDLE;
                  end
               end
               default: begin
                  state_ff <= S_IDLE;
               end
            endcase
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;

endmodule

// ===== rtl/ffra_checker.sv =====
module ffra_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [ffra_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import ffra_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // one request at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] == ST_OK) || (rsp_tdata[2:0] == ST_NOFIT) ||
                     (rsp_tdata[2:0] == ST_NOTALLOC) || (rsp_tdata[2:0] == ST_FULL) ||
                     (rsp_tdata[2:0] == ST_ZERO))
      else $error("bad status code");

   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] != ST_OK) |-> rsp_tdata[26:3] == '0)
      else $error("offset granted on failure");

   a_used_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[51:27] <= BLOCK_MAX)
      else $error("used bytes exceed block");

endmodule

bind first_fit_region_allocator_core ffra_checker u_ffra_checker (.*);
